/* src/fpq8_pkg.sv */
// Shared types and constants for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
package fpq8_pkg;
  localparam int WORD_BITS          = 32;
  localparam int FRACTION_BITS_DEF  = 8;
  localparam int OP_BITS            = 4;

  localparam logic [OP_BITS-1:0] OP_ADD      = 4'd0;
  localparam logic [OP_BITS-1:0] OP_SUB      = 4'd1;
  localparam logic [OP_BITS-1:0] OP_MUL      = 4'd2;
  localparam logic [OP_BITS-1:0] OP_DIV      = 4'd3;
  localparam logic [OP_BITS-1:0] OP_MIN      = 4'd4;
  localparam logic [OP_BITS-1:0] OP_MAX      = 4'd5;
  localparam logic [OP_BITS-1:0] OP_INC      = 4'd6;
  localparam logic [OP_BITS-1:0] OP_DEC      = 4'd7;
  localparam logic [OP_BITS-1:0] OP_CMP      = 4'd8;
  localparam logic [OP_BITS-1:0] OP_FROM_INT = 4'd9;
  localparam logic [OP_BITS-1:0] OP_TO_INT   = 4'd10;

  // Per-word results that ride along the pipeline beside the divider.
  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [WORD_BITS-1:0] res;
    logic                 gt;
    logic                 lt;
    logic                 eq;
    logic                 err;
    logic                 neg;
  } side_t;
endpackage

/* src/fixed_point_q8_alu.sv */
// Q24.8 fixed-point ALU top level: a fully pipelined datapath with a bit-per-stage divider.
//
// One word may enter every cycle while the output is not stalled; every operation takes
// the same path through the pipeline, so results keep input order.
// Most of the pipeline is the restoring divider, which resolves one quotient bit per
// pipeline stage over the 32 + FRACTION_BITS bits of the scaled dividend; an input
// register, an operand/multiply stage, a product scaling stage and the output register
// make up the rest. A stall on the master side freezes the whole pipeline.
`timescale 1ns / 1ps
module fixed_point_q8_alu #(
  parameter int FRACTION_BITS = fpq8_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // operand_a [31:0], operand_b [63:32]
  input  logic [2*fpq8_pkg::WORD_BITS-1:0] s_tdata,
  // req_type [3:0]
  input  logic [fpq8_pkg::OP_BITS-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // result_value [31:0], is_greater [32], is_less [33], is_equal [34],
  // error_code [35], zero [39:36]
  output logic [39:0]                   m_tdata
);
  import fpq8_pkg::*;

  localparam int W = WORD_BITS;
  localparam int F = FRACTION_BITS;
  localparam int N = W + F;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input register
  logic                 v0;
  logic [OP_BITS-1:0]   op0;
  logic signed [W-1:0]  a0, b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
    if (en) begin
      op0 <= s_tuser;
      a0  <= s_tdata[W-1:0];
      b0  <= s_tdata[2*W-1:W];
    end
  end

  // operand stage: simple results, magnitudes, product
  side_t                side1_next;
  logic [W-1:0]         ma, mb;
  logic                 lt_ab, gt_ab, eq_ab;

  always_comb begin
    lt_ab = a0 < b0;
    gt_ab = b0 < a0;
    eq_ab = a0 == b0;
    ma    = a0[W-1] ? W'(-a0) : W'(a0);
    mb    = b0[W-1] ? W'(-b0) : W'(b0);
    side1_next     = '0;
    side1_next.op  = op0;
    side1_next.neg = a0[W-1] ^ b0[W-1];
    unique case (op0)
      OP_ADD:      side1_next.res = W'(a0 + b0);
      OP_SUB:      side1_next.res = W'(a0 - b0);
      OP_MIN:      side1_next.res = lt_ab ? a0 : b0;
      OP_MAX:      side1_next.res = gt_ab ? a0 : b0;
      OP_INC:      side1_next.res = W'(a0 + W'(1));
      OP_DEC:      side1_next.res = W'(a0 - W'(1));
      OP_FROM_INT: side1_next.res = W'(a0 <<< F);
      OP_TO_INT:   side1_next.res = W'(a0 >>> F);
      OP_CMP: begin
        side1_next.gt = gt_ab;
        side1_next.lt = lt_ab;
        side1_next.eq = eq_ab;
      end
      OP_DIV:      side1_next.err = (b0 == '0);
      default:     side1_next.res = '0;
    endcase
  end

  logic           v1;
  side_t          side1;
  logic [2*W-1:0] prod1;
  logic [W-1:0]   d1;
  logic [N-1:0]   num1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      side1 <= side1_next;
      prod1 <= (2*W)'(ma) * (2*W)'(mb);
      d1    <= mb;
      num1  <= {ma, {F{1'b0}}};
    end
  end

  // scale the product toward zero and apply the sign
  side_t        side2_next;
  logic [W-1:0] pq;

  always_comb begin
    pq         = prod1[F +: W];
    side2_next = side1;
    if (side1.op == OP_MUL) begin
      side2_next.res = side1.neg ? W'(-pq) : pq;
    end
  end

  // divider pipeline, one quotient bit per stage
  logic         dv   [N+1];
  side_t        dside[N+1];
  logic [W-1:0] dd   [N+1];
  logic [W:0]   drem [N+1];
  logic [N-1:0] dnum [N+1];
  logic [N-1:0] dquo [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v1;
    end
    if (en) begin
      dside[0] <= side2_next;
      dd[0]    <= d1;
      drem[0]  <= '0;
      dnum[0]  <= num1;
      dquo[0]  <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_div
    logic [W:0] rem_sh;
    logic       ge;
    always_comb begin
      rem_sh = {drem[i][W-1:0], dnum[i][N-1]};
      ge     = rem_sh >= {1'b0, dd[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (en) begin
        dv[i+1] <= dv[i];
      end
      if (en) begin
        dside[i+1] <= dside[i];
        dd[i+1]    <= dd[i];
        drem[i+1]  <= ge ? rem_sh - {1'b0, dd[i]} : rem_sh;
        dnum[i+1]  <= dnum[i] << 1;
        dquo[i+1]  <= {dquo[i][N-2:0], ge};
      end
    end
  end

  // output register
  side_t        fin;
  logic [W-1:0] qw;

  always_comb begin
    fin = dside[N];
    qw  = dquo[N][W-1:0];
    if (fin.op == OP_DIV) begin
      fin.res = fin.err ? '0 : (fin.neg ? W'(-qw) : qw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv[N];
    end
    if (en) begin
      m_tdata <= {4'b0, fin.err, fin.eq, fin.lt, fin.gt, fin.res};
    end
  end

  // hold the flags consistent, the division error clean and the output stable under a stall
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[35] |-> m_tdata[31:0] == '0 && m_tdata[34:32] == '0)
    else $error("division error word carries a nonzero result or flags");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[34:32]))
    else $error("more than one compare flag set");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && !$past(s_tready))
    else $error("output word changed or input accepted during a stall");
endmodule

/* sim/testbench.sv */
// Self-checking testbench for the Q24.8 fixed-point ALU stream block.
`timescale 1ns / 1ps
module testbench;
  import fpq8_pkg::*;

  localparam int FRAC      = 8;
  localparam int LATENCY   = FRAC + 36;
  localparam int N_RANDOM  = 1800;
  localparam int WATCHDOG  = 20000;

  typedef struct packed {
    logic [31:0] value;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        err;
  } alu_result_t;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    alu_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [3:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;

  alu_result_t results_due[$];
  int fail_count = 0;
  int words_in = 0;
  int words_out = 0;
  int div_zero_seen = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit stim_done = 1'b0;

  fixed_point_q8_alu u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Compute the expected ALU result for one word.
  function automatic alu_result_t alu_predict(logic [3:0] op, logic [31:0] a_raw,
                                              logic [31:0] b_raw);
    logic signed [63:0] a, b;
    logic [127:0] prod, num, quo;
    logic [63:0] q;
    logic neg;
    alu_result_t r;
    a = {{32{a_raw[31]}}, a_raw};
    b = {{32{b_raw[31]}}, b_raw};
    neg = a[63] ^ b[63];
    r = '0;
    case (op)
      OP_ADD: r.value = a_raw + b_raw;
      OP_SUB: r.value = a_raw - b_raw;
      OP_MUL: begin
        prod = {64'd0, mag64(a)} * {64'd0, mag64(b)};
        q = prod[FRAC +: 64];
        r.value = neg ? -q : q;
      end
      OP_DIV: begin
        if (b == 0) begin
          r.err = 1'b1;
        end else begin
          num = {64'd0, mag64(a)} << FRAC;
          quo = num / {64'd0, mag64(b)};
          q = quo[63:0];
          r.value = neg ? -q : q;
        end
      end
      OP_MIN: r.value = (a < b) ? a_raw : b_raw;
      OP_MAX: r.value = (b < a) ? a_raw : b_raw;
      OP_INC: r.value = a_raw + 32'd1;
      OP_DEC: r.value = a_raw - 32'd1;
      OP_CMP: begin
        r.gt = b < a;
        r.lt = a < b;
        r.eq = a == b;
      end
      OP_FROM_INT: r.value = a_raw << FRAC;
      OP_TO_INT: r.value = $signed(a_raw) >>> FRAC;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Hold valid until the word is taken; random gaps before it unless calm.
  task automatic send_word(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {b, a};
    do @(posedge clk); while (!s_tready);
    results_due.push_back(alu_predict(op, a, b));
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 2047) - 1024;
      4: return {{16{1'b0}}, 16'($urandom)};
      5: return -{{16{1'b0}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Count accepted input words.
  always @(posedge clk) begin
    if (s_tvalid && s_tready) words_in <= words_in + 1;
  end

  // Output side: random stall bursts, then compare with the oldest expectation.
  initial begin : sink
    int stall;
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 11);
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    alu_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      words_out <= words_out + 1;
      if (results_due.size() == 0) begin
        $error("result word with nothing expected: %h", m_tdata);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (want.err) div_zero_seen++;
        if (m_tdata[31:0] !== want.value) begin
          $error("result_value expected %h actual %h", want.value, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tdata[32] !== want.gt) begin
          $error("is_greater expected %b actual %b", want.gt, m_tdata[32]);
          fail_count++;
        end
        if (m_tdata[33] !== want.lt) begin
          $error("is_less expected %b actual %b", want.lt, m_tdata[33]);
          fail_count++;
        end
        if (m_tdata[34] !== want.eq) begin
          $error("is_equal expected %b actual %b", want.eq, m_tdata[34]);
          fail_count++;
        end
        if (m_tdata[35] !== want.err) begin
          $error("error_code expected %b actual %b", want.err, m_tdata[35]);
          fail_count++;
        end
        if (m_tdata[39:36] !== 4'd0) begin
          $error("zero field expected 0 actual %h", m_tdata[39:36]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no word moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (!stim_done || results_due.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("timeout with %0d results outstanding", results_due.size());
        $display("** fixed_point_q8_alu: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t rows[$];
    stim_row_t row;
    logic [3:0] op;
    alu_result_t got;
    int guard;

    // Directed rows; a typed-in result is checked against the predictor too.
    rows.push_back('{OP_ADD, 32'h7fff_ffff, 32'd1, 1, '{32'h8000_0000, 0, 0, 0, 0}});
    rows.push_back('{OP_SUB, 32'h8000_0000, 32'd1, 1, '{32'h7fff_ffff, 0, 0, 0, 0}});
    rows.push_back('{OP_MUL, 32'h0000_0200, 32'h0000_0300, 1, '{32'h0000_0600, 0, 0, 0, 0}});
    rows.push_back('{OP_MUL, 32'hffff_ffff, 32'd1, 1, '{32'd0, 0, 0, 0, 0}});
    rows.push_back('{OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, '0});
    rows.push_back('{OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 0, '0});
    rows.push_back('{OP_DIV, 32'h0000_0300, 32'd0, 1, '{32'd0, 0, 0, 0, 1}});
    rows.push_back('{OP_DIV, 32'h8000_0000, 32'hffff_ff00, 0, '0});
    rows.push_back('{OP_DIV, 32'h8000_0000, 32'hffff_ffff, 0, '0});
    rows.push_back('{OP_DIV, 32'hffff_fd00, 32'h0000_0200, 1, '{32'hffff_fe80, 0, 0, 0, 0}});
    rows.push_back('{OP_DIV, 32'h7fff_ffff, 32'd1, 0, '0});
    rows.push_back('{OP_MIN, 32'h8000_0000, 32'h7fff_ffff, 1, '{32'h8000_0000, 0, 0, 0, 0}});
    rows.push_back('{OP_MAX, 32'h8000_0000, 32'h7fff_ffff, 1, '{32'h7fff_ffff, 0, 0, 0, 0}});
    rows.push_back('{OP_INC, 32'h7fff_ffff, 32'hffff_ffff, 1, '{32'h8000_0000, 0, 0, 0, 0}});
    rows.push_back('{OP_DEC, 32'h8000_0000, 32'd0, 1, '{32'h7fff_ffff, 0, 0, 0, 0}});
    rows.push_back('{OP_CMP, 32'h8000_0000, 32'h7fff_ffff, 1, '{32'd0, 0, 1, 0, 0}});
    rows.push_back('{OP_CMP, 32'h7fff_ffff, 32'h8000_0000, 1, '{32'd0, 1, 0, 0, 0}});
    rows.push_back('{OP_CMP, 32'h1234_5678, 32'h1234_5678, 1, '{32'd0, 0, 0, 1, 0}});
    rows.push_back('{OP_FROM_INT, 32'h0080_0000, 32'd0, 1, '{32'h8000_0000, 0, 0, 0, 0}});
    rows.push_back('{OP_FROM_INT, 32'hffff_ffff, 32'd0, 1, '{32'hffff_ff00, 0, 0, 0, 0}});
    rows.push_back('{OP_TO_INT, 32'h8000_0000, 32'd0, 1, '{32'hff80_0000, 0, 0, 0, 0}});
    rows.push_back('{OP_TO_INT, 32'hffff_ffff, 32'd0, 1, '{32'hffff_ffff, 0, 0, 0, 0}});
    rows.push_back('{4'd11, 32'h1234_5678, 32'd0, 1, '0});
    rows.push_back('{4'd15, 32'hffff_ffff, 32'hffff_ffff, 1, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      if (row.typed) begin
        got = alu_predict(row.op, row.a, row.b);
        if (got !== row.res) begin
          $error("directed row %0d: typed result %h, predictor %h", i, row.res, got);
          fail_count++;
        end
      end
      send_word(row.op, row.a, row.b);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 200) calm = 1'b1;
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                         : 4'($urandom_range(0, 10));
      if (op == OP_DIV && $urandom_range(0, 15) == 0)
        send_word(op, rand_operand(), 32'd0);
      else
        send_word(op, rand_operand(), rand_operand());
    end
    s_tvalid <= 1'b0;
    stim_done = 1'b1;

    guard = 0;
    while (results_due.size() != 0 && guard < WATCHDOG) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk);

    $display("covered %0d words in, %0d results out, %0d divide-by-zero", words_in,
             words_out, div_zero_seen);
    $display("all eleven operations, unused codes, operand extremes, stalls on both sides");
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("** fixed_point_q8_alu: PASSED **");
    end else begin
      $display("** fixed_point_q8_alu: FAILED **");
    end
    $finish;
  end
endmodule

/* sim.f */
src/fpq8_pkg.sv
src/fixed_point_q8_alu.sv
sim/testbench.sv
